// File: rtl/pps_pkg.sv
// Shared constants and types for the pump speed PID controller.
// No dependencies; imported by pid_pump_speed_controller.
`timescale 1ns / 1ps

package pps_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TARGET_TEMP = 3'd0,
        REG_PROP_GAIN   = 3'd1,
        REG_INTEG_GAIN  = 3'd2,
        REG_DERIV_GAIN  = 3'd3,
        REG_FLUSH_MODE  = 3'd4
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int TEMP_W     = 12;
    localparam int GAIN_W     = 20;
    localparam int ERR_W      = 13;
    localparam int DERR_W     = 14;
    localparam int INTEG_W    = 32;
    localparam int DRIVE_W    = 13;
    localparam int ACC_W      = 54;
    localparam int Y_W        = 23;
    localparam int RECIP_W    = 24;
    localparam int RECIP_SH   = 33;

    // Reset values of the configuration registers
    localparam logic signed [TEMP_W-1:0] TARGET_RST = 12'sd800;
    localparam logic [GAIN_W-1:0]        PROP_RST   = 20'd45000;
    localparam logic [GAIN_W-1:0]        INTEG_RST  = 20'd10000;
    localparam logic [GAIN_W-1:0]        DERIV_RST  = 20'd300000;

    // Drive limits and flush value
    localparam logic [DRIVE_W-1:0] DRIVE_MIN   = 13'd1350;
    localparam logic [DRIVE_W-1:0] DRIVE_MAX   = 13'd8190;
    localparam logic [DRIVE_W-1:0] DRIVE_FLUSH = 13'd5000;

    // Accumulator thresholds (drive * 160000)
    localparam logic signed [ACC_W-1:0] ACC_CLIP_LO = 54'sd216000000;   // 1350
    localparam logic signed [ACC_W-1:0] ACC_PIN_LO  = 54'sd216160000;   // 1351
    localparam logic signed [ACC_W-1:0] ACC_PIN_HI  = 54'sd1310400000;  // 8190

    // 160000 = 256 * 625: shift by 8, then reciprocal multiply for /625
    localparam logic [Y_W-1:0]     Y_MIN = 23'd843750;   // 1350 * 625
    localparam logic [Y_W-1:0]     Y_MAX = 23'd5118750;  // 8190 * 625
    localparam logic [RECIP_W-1:0] RECIP = 24'd13743896; // ceil(2^33 / 625)

    localparam logic signed [INTEG_W:0] INTEG_HI = 33'sd2147483647;
    localparam logic signed [INTEG_W:0] INTEG_LO = -33'sd2147483648;

endpackage

// File: rtl/pid_pump_speed_controller.sv
// Pump speed PID controller with conditional-integration anti-windup.
// Depends on pps_pkg.
`timescale 1ns / 1ps

// Usage
// - Input channel: in_valid / in_stall with hot_temp (signed 1/16 degree).
//   One item in gives exactly one pump_drive item out.
// - Output channel: out_valid / out_stall with pump_drive (1350..8190, or
//   5000 in flush mode).
// - Config: cfg_we / cfg_index / cfg_data, written while no item is in flight.
//   Unknown indexes are ignored.
// - Three-stage pipeline: sample register, loop stage (PID products, integral
//   update, clip compares), scale stage (divide by 160000 via shift and
//   reciprocal multiply).
// - Throughput is one item per cycle while out_stall is low. The loop stage
//   holds the only feedback path: the integral and the pinned-at-limit flags
//   are updated as each sample leaves it, so the next sample follows directly.
// - Output stall stops stages back to front; each stage still fills a bubble
//   ahead of it, so the block takes new items while a result waits.
// - Reset loads the register defaults, clears the integral and previous error,
//   and marks the previous drive as pinned low (drive of zero).

module pid_pump_speed_controller
    import pps_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [TEMP_W-1:0]  hot_temp,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [DRIVE_W-1:0]        pump_drive,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    // Config registers
    logic signed [TEMP_W-1:0] target_reg;
    logic [GAIN_W-1:0]        prop_reg;
    logic [GAIN_W-1:0]        integ_gain_reg;
    logic [GAIN_W-1:0]        deriv_reg;
    logic                     flush_reg;

    // Loop state
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [ERR_W-1:0]   prev_err_reg;
    logic                      drv_hi_reg;   // previous drive at 8190
    logic                      drv_lo_reg;   // previous drive at the 1350 floor (or zero)

    // Pipeline
    logic                     s1_valid_reg;
    logic signed [TEMP_W-1:0] s1_temp_reg;
    logic                     s2_valid_reg;
    logic [Y_W-1:0]           y_reg;
    logic [Y_W-1:0]           y_next;
    logic                     s2_flush_reg;
    logic                     out_valid_reg;
    logic [DRIVE_W-1:0]       drive_reg;
    logic [DRIVE_W-1:0]       drive_next;

    logic s1_ready, s2_ready, s3_ready;
    logic in_fire, s1_fire, s2_fire;

    // Loop stage datapath
    logic signed [ERR_W-1:0]    err;
    logic signed [DERR_W-1:0]   derr;
    logic                       hold;
    logic signed [INTEG_W:0]    isum;
    logic signed [GAIN_W:0]     prop_s, integ_s, deriv_s;
    logic signed [GAIN_W+ERR_W-1:0]   prod_p;
    logic signed [GAIN_W+DERR_W-1:0]  prod_d;
    logic signed [GAIN_W+INTEG_W:0]   prod_i;
    logic signed [ACC_W-1:0]    acc;
    logic [Y_W+RECIP_W-1:0]     q_prod;

    // Handshake
    assign s3_ready = !out_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;
    assign in_fire  = in_valid && s1_ready;
    assign s1_fire  = s1_valid_reg && s2_ready;
    assign s2_fire  = s2_valid_reg && s3_ready;

    assign out_valid  = out_valid_reg;
    assign pump_drive = drive_reg;

    // Error, derivative and integral with anti-windup hold
    always_comb
    begin
        err  = ERR_W'(s1_temp_reg) - ERR_W'(target_reg);
        derr = DERR_W'(err) - DERR_W'(prev_err_reg);
        hold = (drv_hi_reg && (err > 0)) || (drv_lo_reg && (err < 0));
        isum = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err);
        if (hold)
        begin
            integ_next = integ_reg;
        end
        else if (isum > INTEG_HI)
        begin
            integ_next = INTEG_HI[INTEG_W-1:0];
        end
        else if (isum < INTEG_LO)
        begin
            integ_next = INTEG_LO[INTEG_W-1:0];
        end
        else
        begin
            integ_next = isum[INTEG_W-1:0];
        end
    end

    // Gain products and weighted sum (prop x10, deriv x50)
    always_comb
    begin
        prop_s  = $signed({1'b0, prop_reg});
        integ_s = $signed({1'b0, integ_gain_reg});
        deriv_s = $signed({1'b0, deriv_reg});
        prod_p  = prop_s * err;
        prod_d  = deriv_s * derr;
        prod_i  = integ_s * integ_next;
        acc     = ACC_W'(prod_p) * 54'sd10 + ACC_W'(prod_d) * 54'sd50 + ACC_W'(prod_i);
    end

    // Clip in the accumulator domain, then drop the factor of 256
    always_comb
    begin
        if (acc < ACC_CLIP_LO)
        begin
            y_next = Y_MIN;
        end
        else if (acc >= ACC_PIN_HI)
        begin
            y_next = Y_MAX;
        end
        else
        begin
            y_next = acc[Y_W+7:8];
        end
    end

    // Divide by 625 (exact for y below 2^23)
    always_comb
    begin
        q_prod = (Y_W+RECIP_W)'(y_reg) * (Y_W+RECIP_W)'(RECIP);
        if (s2_flush_reg)
        begin
            drive_next = DRIVE_FLUSH;
        end
        else
        begin
            drive_next = q_prod[RECIP_SH+DRIVE_W-1:RECIP_SH];
        end
    end

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= TARGET_RST;
            prop_reg       <= PROP_RST;
            integ_gain_reg <= INTEG_RST;
            deriv_reg      <= DERIV_RST;
            flush_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_TARGET_TEMP: target_reg     <= $signed(cfg_data[TEMP_W-1:0]);
                REG_PROP_GAIN:   prop_reg       <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:  integ_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:  deriv_reg      <= cfg_data[GAIN_W-1:0];
                REG_FLUSH_MODE:  flush_reg      <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Loop state and pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            drv_hi_reg    <= 1'b0;
            drv_lo_reg    <= 1'b1;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (s1_fire)
            begin
                integ_reg    <= integ_next;
                prev_err_reg <= err;
                drv_hi_reg   <= !flush_reg && (acc >= ACC_PIN_HI);
                drv_lo_reg   <= !flush_reg && (acc < ACC_PIN_LO);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_temp_reg <= hot_temp;
        end
        if (s1_fire)
        begin
            y_reg        <= y_next;
            s2_flush_reg <= flush_reg;
        end
        if (s2_fire)
        begin
            drive_reg <= drive_next;
        end
    end

    // Assertions
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (drive_reg >= DRIVE_MIN) && (drive_reg <= DRIVE_MAX))
        else $error("pump_drive out of range");

    a_pin_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({drv_hi_reg, drv_lo_reg}))
        else $error("drive pinned at both limits");

    a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (y_reg >= Y_MIN) && (y_reg <= Y_MAX))
        else $error("scaled sum outside clip range");

    a_hold_low: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && drv_lo_reg && (err < 0)) |=> (integ_reg == $past(integ_reg)))
        else $error("integral moved while pinned low");

    a_hold_high: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && drv_hi_reg && (err > 0)) |=> (integ_reg == $past(integ_reg)))
        else $error("integral moved while pinned high");

endmodule
